// ----- sv/dvrt_pkg.sv -----
`default_nettype none
// -----------------------------------------------------------------------------
// dvrt_pkg
// shared codes, field widths and transaction types of the distance-vector
// route table
// -----------------------------------------------------------------------------
package dvrt_pkg;

   localparam int ID_W             = 3;
   localparam int ADV_LANES        = 6;
   localparam int ADV_COST_W       = 8;
   localparam int RESET_MASK_W     = 6;
   localparam int NBR_MASK_W       = 6;
   localparam int AGE_W            = 8;
   localparam int CSR_INDEX_W      = 3;
   localparam int CSR_DATA_W       = 48;
   localparam int INIT_COSTS_W     = 48;
   localparam int INIT_HOPS_W      = 18;
   localparam int INIT_SHIFT_LIMIT = 64;

   localparam logic [ID_W-1:0]         HOP_NONE       = 3'd7;
   localparam logic [ADV_COST_W-1:0]   ADV_UNREACH    = 8'hFF;
   localparam logic [ADV_COST_W-1:0]   ROUTE_COST_MAX = 8'hFF;
   localparam logic [AGE_W-1:0]        AGE_MAX        = 8'hFF;
   localparam logic [INIT_COSTS_W-1:0] INIT_COSTS_RST = 48'hFFFF_FFFF_FFFF;
   localparam logic [INIT_HOPS_W-1:0]  INIT_HOPS_RST  = 18'h3FFFF;
   localparam logic [AGE_W-1:0]        TIMEOUT_RST    = 8'd10;

   typedef enum logic [1:0] {
      REQ_ADVERT    = 2'd0,
      REQ_LOOKUP    = 2'd1,
      REQ_NBR_RESET = 2'd2,
      REQ_TICK      = 2'd3
   } req_code_type;

   typedef enum logic [1:0] {
      ROUTE_FORWARD = 2'd0,
      ROUTE_LOCAL   = 2'd1,
      ROUTE_NONE    = 2'd2
   } route_status_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_SELF_INDEX   = 3'd0,
      CSR_NBR_MASK     = 3'd1,
      CSR_INIT_COSTS   = 3'd2,
      CSR_INIT_HOPS    = 3'd3,
      CSR_DEAD_TIMEOUT = 3'd4
   } csr_index_type;

   typedef struct packed {
      req_code_type                           kind;
      logic [ID_W-1:0]                        router_id;
      logic [ADV_LANES-1:0][ADV_COST_W-1:0]   cost;
   } req_fields_type;

   typedef struct packed {
      route_status_type                       status;
      logic [ID_W-1:0]                        hop;
      logic [ADV_COST_W-1:0]                  cost;
   } lookup_type;

   typedef struct packed {
      logic                                   table_changed;
      route_status_type                       route_status;
      logic [ID_W-1:0]                        next_hop;
      logic [ADV_COST_W-1:0]                  route_cost;
      logic [RESET_MASK_W-1:0]                reset_mask;
   } rsp_fields_type;

endpackage
`default_nettype wire

// ----- sv/dvrt_relax.sv -----
`default_nettype none
// -----------------------------------------------------------------------------
// dvrt_relax
// advertisement lanes: per-destination saturating add and compare, revive of
// the advertiser and link cost update
// -----------------------------------------------------------------------------
module dvrt_relax import dvrt_pkg::*; #(
   parameter int ROUTERS   = 6,
   parameter int COST_BITS = 8
) (
   input  logic [ID_W-1:0]                         router_id,
   input  logic [ID_W-1:0]                         self_index,
   input  logic [ADV_LANES-1:0][ADV_COST_W-1:0]    adv_cost_raw,
   input  logic [ROUTERS-1:0][COST_BITS-1:0]       cost_cur,
   input  logic [ROUTERS-1:0][ID_W-1:0]            hop_cur,
   input  logic [ROUTERS-1:0]                      dead_cur,
   input  logic [ROUTERS-1:0]                      nbr_mask,
   output logic                                    active,
   output logic                                    changed,
   output logic [ROUTERS-1:0][COST_BITS-1:0]       cost_next,
   output logic [ROUTERS-1:0][ID_W-1:0]            hop_next,
   output logic [ROUTERS-1:0]                      dead_next,
   output logic [ROUTERS-1:0]                      age_clear
);

   localparam logic [COST_BITS-1:0] COST_INF     = '1;
   localparam int                   CMP_W        =
      ((COST_BITS > ADV_COST_W) ? COST_BITS : ADV_COST_W) + 1;
   localparam logic [ID_W-1:0]      ROUTER_LIMIT = ID_W'(ROUTERS);

   function automatic logic [COST_BITS-1:0] adv_cost(input logic [ADV_COST_W-1:0] v);
      logic [CMP_W-1:0] vx;
      vx = CMP_W'(v);
      if (v == ADV_UNREACH || vx >= CMP_W'(COST_INF)) begin
         return COST_INF;
      end
      return COST_BITS'(v);
   endfunction

   logic [ROUTERS-1:0][COST_BITS-1:0] adv_lane;
   logic [ROUTERS-1:0]                hit;
   logic [ROUTERS-1:0]                update;
   logic [COST_BITS-1:0]              via;
   logic [COST_BITS-1:0]              self_cost;
   logic                              was_dead;

   for (genvar d = 0; d < ROUTERS; d++) begin : g_lane
      logic [COST_BITS:0]   sum;
      logic [COST_BITS-1:0] sat;
      logic [COST_BITS-1:0] eff;

      assign hit[d] = (router_id == ID_W'(d));

      if (d < ADV_LANES) begin : g_adv
         assign adv_lane[d] = adv_cost(adv_cost_raw[d]);
      end else begin : g_noadv
         assign adv_lane[d] = COST_INF;
      end

      assign sum       = {1'b0, via} + {1'b0, adv_lane[d]};
      assign sat       = (sum >= {1'b0, COST_INF}) ? COST_INF : sum[COST_BITS-1:0];
      // advertiser is revived before relaxation
      assign eff       = (dead_cur[d] && !hit[d]) ? COST_INF : cost_cur[d];
      assign update[d] = (self_index != ID_W'(d)) && (via != COST_INF) &&
                         (adv_lane[d] != COST_INF) && (sat < eff);

      assign cost_next[d] = hit[d] ? self_cost : (update[d] ? sat : cost_cur[d]);
      assign hop_next[d]  = update[d] ? router_id : hop_cur[d];
      assign dead_next[d] = dead_cur[d] && !hit[d];
      assign age_clear[d] = hit[d] && nbr_mask[d];
   end

   always_comb begin
      via       = '0;
      was_dead  = 1'b0;
      self_cost = COST_INF;
      for (int i = 0; i < ROUTERS; i++) begin
         if (hit[i]) begin
            via      = via | cost_cur[i];
            was_dead = was_dead | dead_cur[i];
         end
         if (self_index == ID_W'(i)) begin
            self_cost = adv_lane[i];
         end
      end
   end

   assign active  = (router_id < ROUTER_LIMIT) && (router_id != self_index);
   assign changed = was_dead || (|update);

endmodule
`default_nettype wire

// ----- sv/dvrt_age.sv -----
`default_nettype none
// -----------------------------------------------------------------------------
// dvrt_age
// tick handling: neighbour aging and selection of neighbours to reset, with
// later candidates judged against the reloaded table once one reset fires
// -----------------------------------------------------------------------------
module dvrt_age import dvrt_pkg::*; #(
   parameter int ROUTERS   = 6,
   parameter int COST_BITS = 8
) (
   input  logic [ROUTERS-1:0]                nbr_mask,
   input  logic [ROUTERS-1:0][AGE_W-1:0]     age_cur,
   input  logic [AGE_W-1:0]                  dead_timeout,
   input  logic [ROUTERS-1:0]                dead_cur,
   input  logic [ROUTERS-1:0][COST_BITS-1:0] cost_cur,
   input  logic [ROUTERS-1:0][COST_BITS-1:0] init_cost,
   output logic [ROUTERS-1:0][AGE_W-1:0]     age_next,
   output logic [ROUTERS-1:0]                reset_mask
);

   localparam logic [COST_BITS-1:0] COST_INF = '1;

   logic [ROUTERS-1:0] elig_cur;
   logic [ROUTERS-1:0] elig_init;

   for (genvar d = 0; d < ROUTERS; d++) begin : g_nbr
      logic cond;

      assign age_next[d]  = (nbr_mask[d] && age_cur[d] != AGE_MAX) ?
                            age_cur[d] + AGE_W'(1) : age_cur[d];

      assign cond         = nbr_mask[d] && (age_next[d] > dead_timeout);
      assign elig_cur[d]  = cond && !dead_cur[d] && (cost_cur[d] != COST_INF);
      assign elig_init[d] = cond && !dead_cur[d] && (init_cost[d] != COST_INF);
   end

   always_comb begin
      logic fired;
      fired = 1'b0;
      for (int d = 0; d < ROUTERS; d++) begin
         reset_mask[d] = fired ? elig_init[d] : elig_cur[d];
         fired         = fired | elig_cur[d];
      end
   end

endmodule
`default_nettype wire

// ----- sv/dvrt_lookup.sv -----
`default_nettype none
// -----------------------------------------------------------------------------
// dvrt_lookup
// route lookup: local delivery, forward with next hop and cost, or no route
// -----------------------------------------------------------------------------
module dvrt_lookup import dvrt_pkg::*; #(
   parameter int ROUTERS   = 6,
   parameter int COST_BITS = 8
) (
   input  logic [ID_W-1:0]                   router_id,
   input  logic [ID_W-1:0]                   self_index,
   input  logic [ROUTERS-1:0][COST_BITS-1:0] cost_cur,
   input  logic [ROUTERS-1:0][ID_W-1:0]      hop_cur,
   input  logic [ROUTERS-1:0]                dead_cur,
   output lookup_type                        result
);

   localparam logic [COST_BITS-1:0] COST_INF     = '1;
   localparam logic [ID_W-1:0]      ROUTER_LIMIT = ID_W'(ROUTERS);
   localparam int                   CMP_W        =
      ((COST_BITS > ADV_COST_W) ? COST_BITS : ADV_COST_W) + 1;

   logic [COST_BITS-1:0] cost_sel;
   logic [ID_W-1:0]      hop_sel;
   logic                 dead_sel;
   logic                 in_range;
   logic [CMP_W-1:0]     cost_wide;

   always_comb begin
      cost_sel = '0;
      hop_sel  = '0;
      dead_sel = 1'b0;
      for (int i = 0; i < ROUTERS; i++) begin
         if (router_id == ID_W'(i)) begin
            cost_sel = cost_sel | cost_cur[i];
            hop_sel  = hop_sel | hop_cur[i];
            dead_sel = dead_sel | dead_cur[i];
         end
      end
   end

   assign in_range  = (router_id < ROUTER_LIMIT);
   assign cost_wide = CMP_W'(cost_sel);

   always_comb begin
      result.status = ROUTE_NONE;
      result.hop    = HOP_NONE;
      result.cost   = ROUTE_COST_MAX;
      if (in_range && router_id == self_index) begin
         result.status = ROUTE_LOCAL;
         result.cost   = '0;
      end else if (in_range && !dead_sel && cost_sel != COST_INF &&
                   hop_sel < ROUTER_LIMIT) begin
         result.status = ROUTE_FORWARD;
         result.hop    = hop_sel;
         result.cost   = (cost_wide > CMP_W'(ROUTE_COST_MAX)) ?
                         ROUTE_COST_MAX : ADV_COST_W'(cost_sel);
      end
   end

endmodule
`default_nettype wire

// ----- sv/distance_vector_route_table_top.sv -----
`default_nettype none
// -----------------------------------------------------------------------------
// distance_vector_route_table_top
// six-entry distance-vector route table with advertisement relaxation, route
// lookup, neighbour reset and neighbour aging
// -----------------------------------------------------------------------------
// channel   direction  handshake            payload
// req       in         req_valid/req_stall  req_type, req_router_id, req_cost_0..5
// rsp       out        rsp_valid/rsp_stall  rsp_table_changed, rsp_route_status,
//                                           rsp_next_hop, rsp_route_cost, rsp_reset_mask
// csr       in         csr_write_enable     csr_index, csr_write_data
//
// one transaction per cycle sustained while rsp_stall is low
// the table update and result are formed in one pass between the input
// register and the result register
// reset is synchronous and loads the table from the reset initial values
// a stalled result holds the input register; req_stall rises only when both
// registers are full and rsp_stall is high
// -----------------------------------------------------------------------------
module distance_vector_route_table_top import dvrt_pkg::*; #(
   parameter int ROUTERS   = 6,
   parameter int COST_BITS = 8
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_write_enable,
   input  logic [CSR_INDEX_W-1:0]   csr_index,
   input  logic [CSR_DATA_W-1:0]    csr_write_data,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [1:0]               req_type,
   input  logic [ID_W-1:0]          req_router_id,
   input  logic [ADV_COST_W-1:0]    req_cost_0,
   input  logic [ADV_COST_W-1:0]    req_cost_1,
   input  logic [ADV_COST_W-1:0]    req_cost_2,
   input  logic [ADV_COST_W-1:0]    req_cost_3,
   input  logic [ADV_COST_W-1:0]    req_cost_4,
   input  logic [ADV_COST_W-1:0]    req_cost_5,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic                     rsp_table_changed,
   output logic [1:0]               rsp_route_status,
   output logic [ID_W-1:0]          rsp_next_hop,
   output logic [ADV_COST_W-1:0]    rsp_route_cost,
   output logic [RESET_MASK_W-1:0]  rsp_reset_mask
);

   localparam int COST_EXT_W = INIT_SHIFT_LIMIT + ROUTERS * COST_BITS;
   localparam int HOP_EXT_W  = INIT_HOPS_W + ID_W * ROUTERS;

   typedef logic [ROUTERS-1:0][COST_BITS-1:0] cost_arr_type;
   typedef logic [ROUTERS-1:0][ID_W-1:0]      hop_arr_type;
   typedef logic [ROUTERS-1:0][AGE_W-1:0]     age_arr_type;

   function automatic cost_arr_type unpack_costs(input logic [INIT_COSTS_W-1:0] v);
      logic [COST_EXT_W-1:0] ext;
      cost_arr_type          r;
      ext = COST_EXT_W'(v);
      for (int i = 0; i < ROUTERS; i++) begin
         if (i * COST_BITS < INIT_SHIFT_LIMIT) begin
            r[i] = ext[i*COST_BITS +: COST_BITS];
         end else begin
            r[i] = '1;
         end
      end
      return r;
   endfunction

   function automatic hop_arr_type unpack_hops(input logic [INIT_HOPS_W-1:0] v);
      logic [HOP_EXT_W-1:0] ext;
      hop_arr_type          r;
      ext = HOP_EXT_W'(v);
      for (int i = 0; i < ROUTERS; i++) begin
         r[i] = ext[i*ID_W +: ID_W];
      end
      return r;
   endfunction

   // handshake
   logic           in_valid_ff, in_valid_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           accept, advance;
   req_fields_type in_ff;
   req_fields_type req_fields;
   rsp_fields_type rsp_ff, rsp_in;

   // configuration
   logic [ID_W-1:0]         self_ff, self_in;
   logic [NBR_MASK_W-1:0]   nbr_ff, nbr_in;
   logic [INIT_COSTS_W-1:0] init_costs_ff, init_costs_in;
   logic [INIT_HOPS_W-1:0]  init_hops_ff, init_hops_in;
   logic [AGE_W-1:0]        timeout_ff, timeout_in;

   // table
   cost_arr_type       cost_ff, cost_in;
   hop_arr_type        hop_ff, hop_in;
   logic [ROUTERS-1:0] dead_ff, dead_in;
   age_arr_type        age_ff, age_in;

   cost_arr_type       init_cost_arr;
   hop_arr_type        init_hop_arr;
   logic [ROUTERS-1:0] nbr_ext;
   logic [ROUTERS-1:0] nbr_hit_mask;

   logic               relax_active, relax_changed;
   cost_arr_type       relax_cost;
   hop_arr_type        relax_hop;
   logic [ROUTERS-1:0] relax_dead, relax_age_clear;
   age_arr_type        tick_age;
   logic [ROUTERS-1:0] tick_rmask;
   lookup_type         lookup;

   assign req_fields.kind      = req_code_type'(req_type);
   assign req_fields.router_id = req_router_id;
   assign req_fields.cost      = {req_cost_5, req_cost_4, req_cost_3,
                                  req_cost_2, req_cost_1, req_cost_0};

   assign advance     = in_valid_ff && !(rsp_valid_ff && rsp_stall);
   assign req_stall   = in_valid_ff && !advance;
   assign accept      = req_valid && !req_stall;
   assign in_valid_in = accept || (in_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && rsp_stall);

   assign init_cost_arr = unpack_costs(init_costs_ff);
   assign init_hop_arr  = unpack_hops(init_hops_ff);
   assign nbr_ext       = ROUTERS'(nbr_ff);

   always_comb begin
      for (int i = 0; i < ROUTERS; i++) begin
         nbr_hit_mask[i] = (in_ff.router_id == ID_W'(i)) && nbr_ext[i];
      end
   end

   dvrt_relax #(
      .ROUTERS   (ROUTERS),
      .COST_BITS (COST_BITS)
   ) u_relax (
      .router_id    (in_ff.router_id),
      .self_index   (self_ff),
      .adv_cost_raw (in_ff.cost),
      .cost_cur     (cost_ff),
      .hop_cur      (hop_ff),
      .dead_cur     (dead_ff),
      .nbr_mask     (nbr_ext),
      .active       (relax_active),
      .changed      (relax_changed),
      .cost_next    (relax_cost),
      .hop_next     (relax_hop),
      .dead_next    (relax_dead),
      .age_clear    (relax_age_clear)
   );

   dvrt_age #(
      .ROUTERS   (ROUTERS),
      .COST_BITS (COST_BITS)
   ) u_age (
      .nbr_mask     (nbr_ext),
      .age_cur      (age_ff),
      .dead_timeout (timeout_ff),
      .dead_cur     (dead_ff),
      .cost_cur     (cost_ff),
      .init_cost    (init_cost_arr),
      .age_next     (tick_age),
      .reset_mask   (tick_rmask)
   );

   dvrt_lookup #(
      .ROUTERS   (ROUTERS),
      .COST_BITS (COST_BITS)
   ) u_lookup (
      .router_id  (in_ff.router_id),
      .self_index (self_ff),
      .cost_cur   (cost_ff),
      .hop_cur    (hop_ff),
      .dead_cur   (dead_ff),
      .result     (lookup)
   );

   always_comb begin
      self_in       = self_ff;
      nbr_in        = nbr_ff;
      init_costs_in = init_costs_ff;
      init_hops_in  = init_hops_ff;
      timeout_in    = timeout_ff;
      cost_in       = cost_ff;
      hop_in        = hop_ff;
      dead_in       = dead_ff;
      age_in        = age_ff;
      rsp_in        = '0;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_SELF_INDEX: begin
               self_in = csr_write_data[ID_W-1:0];
            end
            CSR_NBR_MASK: begin
               nbr_in = csr_write_data[NBR_MASK_W-1:0];
            end
            CSR_INIT_COSTS: begin
               init_costs_in = csr_write_data[INIT_COSTS_W-1:0];
               cost_in       = unpack_costs(csr_write_data[INIT_COSTS_W-1:0]);
            end
            CSR_INIT_HOPS: begin
               init_hops_in = csr_write_data[INIT_HOPS_W-1:0];
               hop_in       = unpack_hops(csr_write_data[INIT_HOPS_W-1:0]);
            end
            CSR_DEAD_TIMEOUT: begin
               timeout_in = csr_write_data[AGE_W-1:0];
            end
            default: begin
            end
         endcase
      end else if (advance) begin
         unique case (in_ff.kind)
            REQ_ADVERT: begin
               if (relax_active) begin
                  cost_in              = relax_cost;
                  hop_in               = relax_hop;
                  dead_in              = relax_dead;
                  rsp_in.table_changed = relax_changed;
                  for (int i = 0; i < ROUTERS; i++) begin
                     if (relax_age_clear[i]) begin
                        age_in[i] = '0;
                     end
                  end
               end
            end
            REQ_LOOKUP: begin
               rsp_in.route_status = lookup.status;
               rsp_in.next_hop     = lookup.hop;
               rsp_in.route_cost   = lookup.cost;
            end
            REQ_NBR_RESET: begin
               dead_in           = dead_ff | nbr_hit_mask;
               cost_in           = init_cost_arr;
               hop_in            = init_hop_arr;
               rsp_in.reset_mask = RESET_MASK_W'(nbr_hit_mask);
            end
            REQ_TICK: begin
               age_in            = tick_age;
               rsp_in.reset_mask = RESET_MASK_W'(tick_rmask);
               if (|tick_rmask) begin
                  dead_in = dead_ff | tick_rmask;
                  cost_in = init_cost_arr;
                  hop_in  = init_hop_arr;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         self_ff       <= '0;
         nbr_ff        <= '0;
         init_costs_ff <= INIT_COSTS_RST;
         init_hops_ff  <= INIT_HOPS_RST;
         timeout_ff    <= TIMEOUT_RST;
         cost_ff       <= unpack_costs(INIT_COSTS_RST);
         hop_ff        <= unpack_hops(INIT_HOPS_RST);
         dead_ff       <= '0;
         age_ff        <= '0;
      end else begin
         in_valid_ff   <= in_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         self_ff       <= self_in;
         nbr_ff        <= nbr_in;
         init_costs_ff <= init_costs_in;
         init_hops_ff  <= init_hops_in;
         timeout_ff    <= timeout_in;
         cost_ff       <= cost_in;
         hop_ff        <= hop_in;
         dead_ff       <= dead_in;
         age_ff        <= age_in;
      end
   end

   // transaction payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         in_ff <= req_fields;
      end
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_table_changed = rsp_ff.table_changed;
   assign rsp_route_status  = rsp_ff.route_status;
   assign rsp_next_hop      = rsp_ff.next_hop;
   assign rsp_route_cost    = rsp_ff.route_cost;
   assign rsp_reset_mask    = rsp_ff.reset_mask;

   a_full_pipe_stalls: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && rsp_valid_ff && rsp_stall |-> req_stall)
      else $error("input accepted while both stages are full");

   a_no_route_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.route_status == ROUTE_NONE |->
      rsp_ff.next_hop == HOP_NONE && rsp_ff.route_cost == ROUTE_COST_MAX)
      else $error("no-route result with hop or cost set");

   a_local_cost_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.route_status == ROUTE_LOCAL |->
      rsp_ff.route_cost == '0 && rsp_ff.next_hop == HOP_NONE)
      else $error("local delivery with nonzero cost or a next hop");

   a_reset_fields_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.reset_mask != '0 |->
      !rsp_ff.table_changed && rsp_ff.route_status == ROUTE_FORWARD)
      else $error("reset mask reported together with other fields");

   a_tick_marks_dead: assert property (@(posedge clock) disable iff (reset)
      advance && in_ff.kind == REQ_TICK |=>
      (dead_ff & $past(tick_rmask)) == $past(tick_rmask))
      else $error("neighbour reset by tick not marked dead");

endmodule
`default_nettype wire

// ----- tb/sv/tb_distance_vector_route_table_top.sv -----
`default_nettype none
// -----------------------------------------------------------------------------
// tb_distance_vector_route_table_top
// self-checking testbench of the distance-vector route table: a queue-fed
// driver offers advertisements, lookups, neighbour resets and ticks, a local
// route table model predicts every reply at acceptance, and a monitor compares
// each reply field by field while both sides idle and stall at random
// -----------------------------------------------------------------------------
module tb_distance_vector_route_table_top import dvrt_pkg::*; ();

   localparam int         NODES       = 6;
   localparam logic [7:0] INF         = 8'hFF;
   localparam int         CYCLE_LIMIT = 100000;
   localparam int         HOLD_AT     = 200;
   localparam int         HOLD_CYCLES = 150;

   typedef struct {
      req_fields_type fields;
      int unsigned    gap;
      bit             drain;
   } route_request_type;

   logic                    clock            = 1'b0;
   logic                    reset            = 1'b1;
   logic                    csr_write_enable = 1'b0;
   logic [CSR_INDEX_W-1:0]  csr_index        = '0;
   logic [CSR_DATA_W-1:0]   csr_write_data   = '0;
   logic                    req_valid        = 1'b0;
   logic                    req_stall;
   req_fields_type          req_payload      = '0;
   logic                    rsp_valid;
   logic                    rsp_stall        = 1'b0;
   logic                    rsp_table_changed;
   logic [1:0]              rsp_route_status;
   logic [ID_W-1:0]         rsp_next_hop;
   logic [ADV_COST_W-1:0]   rsp_route_cost;
   logic [RESET_MASK_W-1:0] rsp_reset_mask;

   // route table model
   logic [2:0]  cfg_self    = '0;
   logic [5:0]  cfg_nbr     = '0;
   logic [47:0] cfg_costs   = INIT_COSTS_RST;
   logic [17:0] cfg_hops    = INIT_HOPS_RST;
   logic [7:0]  cfg_timeout = TIMEOUT_RST;
   logic [7:0]  tbl_cost[NODES];
   logic [2:0]  tbl_hop[NODES];
   bit          tbl_dead[NODES];
   bit          base_dead[NODES];
   logic [7:0]  nbr_age[NODES] = '{default: 8'd0};

   route_request_type request_q[$];
   rsp_fields_type    predicted_q[$];
   int unsigned    issued_count   = 0;
   int unsigned    accepted_count = 0;
   int unsigned    reply_count    = 0;
   int unsigned    error_count    = 0;
   int unsigned    cycle_count    = 0;
   int unsigned    gap_max        = 16;
   int unsigned    stall_max      = 16;
   int unsigned    stall_wait     = 0;
   int unsigned    hold_left      = 0;
   bit             hold_done      = 1'b0;
   bit             drain_ok       = 1'b0;

   distance_vector_route_table_top dut (
      .clock             (clock),
      .reset             (reset),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_type          (req_payload.kind),
      .req_router_id     (req_payload.router_id),
      .req_cost_0        (req_payload.cost[0]),
      .req_cost_1        (req_payload.cost[1]),
      .req_cost_2        (req_payload.cost[2]),
      .req_cost_3        (req_payload.cost[3]),
      .req_cost_4        (req_payload.cost[4]),
      .req_cost_5        (req_payload.cost[5]),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_table_changed (rsp_table_changed),
      .rsp_route_status  (rsp_route_status),
      .rsp_next_hop      (rsp_next_hop),
      .rsp_route_cost    (rsp_route_cost),
      .rsp_reset_mask    (rsp_reset_mask)
   );

   always #5 clock = ~clock;

   function automatic void reload_table();
      for (int i = 0; i < NODES; i++) begin
         tbl_cost[i] = cfg_costs[i*8 +: 8];
         tbl_hop[i]  = cfg_hops[i*3 +: 3];
         tbl_dead[i] = base_dead[i];
      end
   endfunction

   function automatic logic [7:0] live_cost(int i);
      return tbl_dead[i] ? INF : tbl_cost[i];
   endfunction

   function automatic bit is_nbr(int r);
      return (r < NODES) && (cfg_nbr[r] == 1'b1);
   endfunction

   function automatic logic [5:0] drop_neighbour(int r);
      logic [5:0] m = '0;
      if (is_nbr(r)) begin
         base_dead[r] = 1'b1;
         m[r] = 1'b1;
      end
      reload_table();
      return m;
   endfunction

   function automatic rsp_fields_type compute_route_reply(req_fields_type rq);
      rsp_fields_type r;
      int             id;
      logic [7:0]     via;
      logic [7:0]     adv;
      logic [8:0]     sum;
      r  = '0;
      id = int'(rq.router_id);
      case (rq.kind)
         REQ_ADVERT: begin
            if (id < NODES && id != int'(cfg_self)) begin
               if (base_dead[id]) begin
                  base_dead[id] = 1'b0;
                  tbl_dead[id]  = 1'b0;
                  r.table_changed = 1'b1;
               end
               via = live_cost(id);
               for (int d = 0; d < NODES; d++) begin
                  adv = rq.cost[d];
                  if (d != int'(cfg_self) && via != INF && adv != INF) begin
                     sum = {1'b0, via} + {1'b0, adv};
                     if (sum >= {1'b0, INF}) sum = {1'b0, INF};
                     if (sum < {1'b0, live_cost(d)}) begin
                        tbl_cost[d] = sum[7:0];
                        tbl_hop[d]  = id[2:0];
                        r.table_changed = 1'b1;
                     end
                  end
               end
               // link cost to the advertiser comes from its cost to us
               tbl_cost[id] = (int'(cfg_self) < NODES) ? rq.cost[cfg_self] : INF;
               if (is_nbr(id)) nbr_age[id] = 8'd0;
            end
         end
         REQ_LOOKUP: begin
            if (id == int'(cfg_self) && id < NODES) begin
               r.route_status = ROUTE_LOCAL;
               r.next_hop     = HOP_NONE;
               r.route_cost   = 8'd0;
            end else if (id < NODES && !tbl_dead[id] && tbl_cost[id] != INF &&
                         int'(tbl_hop[id]) < NODES) begin
               r.route_status = ROUTE_FORWARD;
               r.next_hop     = tbl_hop[id];
               r.route_cost   = tbl_cost[id];
            end else begin
               r.route_status = ROUTE_NONE;
               r.next_hop     = HOP_NONE;
               r.route_cost   = ROUTE_COST_MAX;
            end
         end
         REQ_NBR_RESET: begin
            r.reset_mask = drop_neighbour(id);
         end
         default: begin
            for (int d = 0; d < NODES; d++) begin
               if (is_nbr(d)) begin
                  if (nbr_age[d] != AGE_MAX) nbr_age[d] = nbr_age[d] + 8'd1;
                  if (nbr_age[d] > cfg_timeout && live_cost(d) != INF)
                     r.reset_mask = r.reset_mask | drop_neighbour(d);
               end
            end
         end
      endcase
      return r;
   endfunction

   task automatic report_failure(string msg);
      $display("ERROR: %s", msg);
      error_count++;
   endtask

   task automatic compare_field(string name, logic [7:0] got, logic [7:0] want);
      if (got !== want)
         report_failure($sformatf("reply %0d: %s is %0h, expected %0h",
                                  reply_count, name, got, want));
   endtask

   task automatic check_reply();
      rsp_fields_type want;
      if (predicted_q.size() == 0) begin
         report_failure($sformatf("reply %0d arrived with nothing predicted", reply_count));
      end else begin
         want = predicted_q.pop_front();
         compare_field("table_changed", 8'(rsp_table_changed), 8'(want.table_changed));
         compare_field("route_status", 8'(rsp_route_status), 8'(want.route_status));
         compare_field("next_hop", 8'(rsp_next_hop), 8'(want.next_hop));
         compare_field("route_cost", rsp_route_cost, want.route_cost);
         compare_field("reset_mask", 8'(rsp_reset_mask), 8'(want.reset_mask));
      end
      reply_count++;
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            predicted_q = {predicted_q, compute_route_reply(req_payload)};
            accepted_count <= accepted_count + 1;
         end
         if (!req_valid || !req_stall) begin
            if (request_q.size() == 0) begin
               req_valid <= 1'b0;
            end else if (request_q[0].gap != 0) begin
               request_q[0].gap = request_q[0].gap - 1;
               req_valid <= 1'b0;
            end else if (request_q[0].drain && predicted_q.size() != 0) begin
               req_valid <= 1'b0;
            end else begin
               req_payload <= request_q[0].fields;
               req_valid   <= 1'b1;
               void'(request_q.pop_front());
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            check_reply();
            stall_wait = $urandom_range(0, stall_max);
         end else if (stall_wait != 0) begin
            stall_wait--;
         end
         rsp_stall <= (stall_wait != 0) || (hold_left != 0);
      end
   end

   // one long receiver hold-off to back the block up
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
         hold_done <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end else if (!hold_done && accepted_count >= HOLD_AT) begin
         hold_left <= HOLD_CYCLES;
         hold_done <= 1'b1;
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         report_failure("timeout waiting for replies");
         $display("Test completed with failures");
         $finish;
      end
   end

   function automatic logic [7:0] random_cost();
      int unsigned pick;
      pick = $urandom_range(0, 9);
      if (pick < 2) return INF;
      if (pick == 2) return 8'($urandom_range(0, 255));
      if (pick == 3) return 8'hFE;
      return 8'($urandom_range(0, 40));
   endfunction

   function automatic logic [47:0] lanes6(logic [7:0] c0, logic [7:0] c1, logic [7:0] c2,
                                         logic [7:0] c3, logic [7:0] c4, logic [7:0] c5);
      return {c5, c4, c3, c2, c1, c0};
   endfunction

   function automatic logic [47:0] random_lanes();
      logic [47:0] v;
      for (int d = 0; d < NODES; d++) v[d*8 +: 8] = random_cost();
      return v;
   endfunction

   function automatic logic [17:0] random_hops();
      logic [17:0] v;
      for (int d = 0; d < NODES; d++) v[d*3 +: 3] = 3'($urandom_range(0, 7));
      return v;
   endfunction

   task automatic push_request(req_code_type kind, logic [ID_W-1:0] rid,
                               logic [47:0] lanes, bit drain = 1'b0);
      route_request_type item;
      item.fields.kind      = kind;
      item.fields.router_id = rid;
      item.fields.cost      = lanes;
      item.gap   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, gap_max);
      item.drain = drain;
      request_q = {request_q, item};
      issued_count++;
   endtask

   task automatic push_random();
      int unsigned      pick;
      logic [ID_W-1:0]  rid;
      req_code_type     kind;
      pick = $urandom_range(0, 99);
      rid  = ($urandom_range(0, 9) == 0) ? ID_W'($urandom_range(6, 7)) :
                                            ID_W'($urandom_range(0, 5));
      if (pick < 45) kind = REQ_ADVERT;
      else if (pick < 78) kind = REQ_LOOKUP;
      else if (pick < 92) kind = REQ_TICK;
      else kind = REQ_NBR_RESET;
      push_request(kind, rid, random_lanes(), drain_ok && ($urandom_range(0, 39) == 0));
   endtask

   task automatic write_register(csr_index_type idx, logic [CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      case (idx)
         CSR_SELF_INDEX: cfg_self = value[2:0];
         CSR_NBR_MASK:   cfg_nbr  = value[5:0];
         CSR_INIT_COSTS: begin
            cfg_costs = value[47:0];
            for (int i = 0; i < NODES; i++) tbl_cost[i] = cfg_costs[i*8 +: 8];
         end
         CSR_INIT_HOPS: begin
            cfg_hops = value[17:0];
            for (int i = 0; i < NODES; i++) tbl_hop[i] = cfg_hops[i*3 +: 3];
         end
         CSR_DEAD_TIMEOUT: cfg_timeout = value[7:0];
         default: ;
      endcase
   endtask

   task automatic configure(logic [2:0] self_id, logic [5:0] nbrs, logic [47:0] costs,
                            logic [17:0] hops, logic [7:0] timeout);
      write_register(CSR_SELF_INDEX, CSR_DATA_W'(self_id));
      write_register(CSR_NBR_MASK, CSR_DATA_W'(nbrs));
      write_register(CSR_INIT_COSTS, costs);
      write_register(CSR_INIT_HOPS, CSR_DATA_W'(hops));
      write_register(CSR_DEAD_TIMEOUT, CSR_DATA_W'(timeout));
   endtask

   task automatic wait_for_drain();
      while (reply_count < issued_count) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   initial begin
      int unsigned burst;
      reload_table();
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // reset configuration
      repeat (12) push_random();
      wait_for_drain();

      // directed: neighbours 1 and 2, self 0
      configure(3'd0, 6'b000110, 48'hFFFF_FF03_0500,
                {3'd7, 3'd7, 3'd7, 3'd2, 3'd1, 3'd7}, 8'd3);
      push_request(REQ_LOOKUP, 3'd0, '0);
      push_request(REQ_LOOKUP, 3'd1, '1);
      push_request(REQ_LOOKUP, 3'd3, '0);
      push_request(REQ_LOOKUP, 3'd6, '0);
      push_request(REQ_LOOKUP, 3'd7, '1);
      push_request(REQ_ADVERT, 3'd1, lanes6(8'd5, 8'd0, 8'd2, 8'd4, 8'd255, 8'd254));
      push_request(REQ_ADVERT, 3'd0, lanes6(8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1));
      push_request(REQ_ADVERT, 3'd6, '0);
      push_request(REQ_ADVERT, 3'd7, '0);
      push_request(REQ_ADVERT, 3'd2, lanes6(8'd3, 8'd250, 8'd0, 8'd253, 8'd1, 8'd255));
      push_request(REQ_ADVERT, 3'd4, lanes6(8'd9, 8'd9, 8'd9, 8'd9, 8'd0, 8'd9));
      push_request(REQ_LOOKUP, 3'd3, '0);
      push_request(REQ_LOOKUP, 3'd4, '0);
      push_request(REQ_LOOKUP, 3'd5, '0);
      push_request(REQ_NBR_RESET, 3'd2, '0);
      push_request(REQ_NBR_RESET, 3'd5, '0);
      push_request(REQ_NBR_RESET, 3'd7, '0);
      push_request(REQ_LOOKUP, 3'd2, '0);
      push_request(REQ_ADVERT, 3'd2, lanes6(8'd2, 8'd1, 8'd0, 8'd1, 8'd1, 8'd1), 1'b1);
      repeat (5) push_request(REQ_TICK, 3'd0, '0);
      push_request(REQ_ADVERT, 3'd1, '0);
      push_request(REQ_ADVERT, 3'd1, '1);
      repeat (110) push_random();
      wait_for_drain();

      for (int phase = 2; phase <= 6; phase++) begin
         gap_max   = 16;
         stall_max = 16;
         drain_ok  = 1'b0;
         burst     = 110;
         case (phase)
            2: begin
               configure(3'($urandom_range(0, 5)), 6'($urandom_range(0, 63)),
                         random_lanes(), random_hops(), 8'($urandom_range(1, 8)));
               burst = 140;
            end
            3: begin
               // back-to-back, no idling on either side
               configure(3'd5, 6'h3F, 48'h0, 18'h0, 8'd255);
               gap_max   = 0;
               stall_max = 0;
               burst     = 120;
            end
            4: configure(3'd7, 6'h3F, random_lanes(), INIT_HOPS_RST, 8'd1);
            5: begin
               configure(3'd3, 6'($urandom_range(0, 63)), random_lanes(), random_hops(),
                         8'd0);
               drain_ok = 1'b1;
               burst    = 130;
            end
            default: configure(3'd6, 6'h00, INIT_COSTS_RST, random_hops(), 8'd1);
         endcase
         repeat (burst) push_random();
         wait_for_drain();
      end

      repeat (8) @(posedge clock);
      if (error_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
`default_nettype wire

// ----- files.f -----
sv/dvrt_pkg.sv
sv/dvrt_relax.sv
sv/dvrt_age.sv
sv/dvrt_lookup.sv
sv/distance_vector_route_table_top.sv
tb/sv/tb_distance_vector_route_table_top.sv
